// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge except while reset is high.
`define BWE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BWE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/bwe_pkg.sv -----
// ----------------------------------------------------------------------------
// Bandwidth estimator package
// Widths, window size, request codes and the structs passed between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bwe_pkg;

  localparam int MEAN_W    = 48;
  localparam int CNT_W     = 32;
  localparam int WINDOW    = 8;
  localparam int WIN_W     = $clog2(WINDOW);
  localparam int SUM_W     = MEAN_W + WIN_W;
  localparam int DVS_W     = CNT_W + 1;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam logic MODE_PUT      = 1'b0;
  localparam logic MODE_UNDERRUN = 1'b1;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_stat_t;

  typedef struct packed {
    logic              en;
    logic              fill;
    logic [WIN_W-1:0]  addr;
    logic [MEAN_W-1:0] data;
  } win_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bwe_in_if.sv -----
// ----------------------------------------------------------------------------
// Bandwidth estimator input channel
// Valid/ready channel carrying one put or underrun request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bwe_in_if import bwe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [MEAN_W-1:0] bw_sample;

  modport source (output valid, output mode, output bw_sample, input ready);
  modport sink   (input valid, input mode, input bw_sample, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bwe_out_if.sv -----
// ----------------------------------------------------------------------------
// Bandwidth estimator result channel
// Valid/ready channel carrying the estimates after each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bwe_out_if import bwe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] overall_bw;
  logic [MEAN_W-1:0] window_avg;
  logic [CNT_W-1:0]  sample_count;

  modport source (output valid, output overall_bw, output window_avg,
                  output sample_count, input ready);
  modport sink   (input valid, input overall_bw, input window_avg,
                  input sample_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bwe_div.sv -----
// ----------------------------------------------------------------------------
// Bandwidth estimator serial divider
// Restoring divider, one quotient bit per cycle, SUM_W steps per division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bwe_div import bwe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  div_ctrl_t ctrl,
  output div_stat_t stat
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SUM_W-1:0]     quo;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [DVS_W:0]       rem_sh;
  logic [DVS_W:0]       rem_sub;
  logic                 ge;

  assign rem_sh  = {rem, quo[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  // partial remainder stays below twice the divisor, so the sign bit decides
  assign ge      = ~rem_sub[DVS_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(SUM_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo <= ctrl.dividend;
      rem <= '0;
      dvs <= ctrl.divisor;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], ge};
      rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign stat.busy     = busy;
  assign stat.done     = done;
  assign stat.quotient = quo;

endmodule

`default_nettype wire

// ----- hw/rtl/bwe_win.sv -----
// ----------------------------------------------------------------------------
// Bandwidth estimator window store
// WINDOW sample slots, ring or fill-all write, one indexed read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bwe_win import bwe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  win_wr_t           wr,
  input  logic [WIN_W-1:0]  rd_addr,
  output logic [MEAN_W-1:0] rd_data,
  output logic              slot0_zero
);

  logic [MEAN_W-1:0] slots [WINDOW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        slots[i] <= '0;
      end
    end else if (wr.en) begin
      for (int i = 0; i < WINDOW; i++) begin
        if (wr.fill || (wr.addr == WIN_W'(i))) begin
          slots[i] <= wr.data;
        end
      end
    end
  end

  assign rd_data    = slots[rd_addr];
  assign slot0_zero = (slots[0] == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/bandwidth_estimator_top.sv -----
// A put request goes through the mean-step division, the window sum and the output register.
// An underrun request skips the division and goes through the window sum and the output register.
// One request at a time: the next is taken only after the current result enters the output register.
// A result stall holds the block until the output register is free.
// A finished result waits in the output register while the next request is taken.
// Synchronous active-high reset clears mean, count, ring position and window store.
// ----------------------------------------------------------------------------
// Bandwidth estimator top level
// Overall running mean and moving window average, sequenced over one divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bandwidth_estimator_top import bwe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bwe_in_if.sink     sample,
  bwe_out_if.source  result
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIVM = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t            state;
  logic              mode_q;
  logic              dir_q;
  logic [MEAN_W-1:0] bw_q;
  logic [MEAN_W-1:0] mean;
  logic [CNT_W-1:0]  count;
  logic [WIN_W-1:0]  ring_pos;
  logic [WIN_W-1:0]  idx;
  logic [SUM_W-1:0]  sum;
  logic [MEAN_W-1:0] avg;
  logic              out_valid;
  logic [MEAN_W-1:0] out_mean;
  logic [MEAN_W-1:0] out_avg;
  logic [CNT_W-1:0]  out_cnt;

  logic              accept;
  logic              up;
  logic [MEAN_W-1:0] diff;
  logic [SUM_W-1:0]  sum_next;
  logic [MEAN_W-1:0] avg_next;
  logic              sum_last;
  logic [WIN_W-1:0]  ring_next;
  logic              out_load;
  logic [MEAN_W-1:0] rd_data;
  logic              slot0_zero;
  div_ctrl_t         div_ctrl;
  div_stat_t         div_stat;
  win_wr_t           win_wr;

  assign accept    = sample.valid && sample.ready;
  assign up        = (sample.bw_sample >= mean);
  assign diff      = up ? (sample.bw_sample - mean) : (mean - sample.bw_sample);
  assign sum_next  = sum + SUM_W'(rd_data);
  assign avg_next  = MEAN_W'(sum_next / SUM_W'(WINDOW));
  assign sum_last  = (idx == WIN_W'(WINDOW - 1));
  assign ring_next = (ring_pos == WIN_W'(WINDOW - 1)) ? '0 : ring_pos + 1'b1;
  assign out_load  = (state == ST_OUT) && (!out_valid || result.ready);

  always_comb begin
    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = SUM_W'(diff);
    div_ctrl.divisor  = DVS_W'(count) + DVS_W'(1);
    case (state)
      ST_IDLE: begin
        div_ctrl.start = accept && (sample.mode == MODE_PUT);
      end
      default: begin
        div_ctrl.start = 1'b0;
      end
    endcase
  end

  assign win_wr.en   = (state == ST_DIVM) && div_stat.done;
  assign win_wr.fill = slot0_zero;
  assign win_wr.addr = ring_next;
  assign win_wr.data = bw_q;

  bwe_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .stat (div_stat)
  );

  bwe_win u_win (
    .clk        (clk),
    .rst        (rst),
    .wr         (win_wr),
    .rd_addr    (idx),
    .rd_data    (rd_data),
    .slot0_zero (slot0_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mean      <= '0;
      count     <= '0;
      ring_pos  <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          idx <= '0;
          if (accept) begin
            state <= (sample.mode == MODE_PUT) ? ST_DIVM : ST_SUM;
          end
        end
        ST_DIVM: begin
          if (div_stat.done) begin
            mean <= dir_q ? (mean + div_stat.quotient[MEAN_W-1:0])
                          : (mean - div_stat.quotient[MEAN_W-1:0]);
            if (count != '1) begin
              count <= count + 1'b1;
            end
            if (!slot0_zero) begin
              ring_pos <= ring_next;
            end
            idx   <= '0;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          idx <= idx + 1'b1;
          if (sum_last) begin
            if (mode_q == MODE_UNDERRUN) begin
              mean  <= avg_next;
              count <= CNT_W'(WINDOW);
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= sample.mode;
      bw_q   <= sample.bw_sample;
      dir_q  <= up;
    end
    if ((state == ST_IDLE) || (state == ST_DIVM)) begin
      sum <= '0;
    end else if (state == ST_SUM) begin
      sum <= sum_next;
    end
    if ((state == ST_SUM) && sum_last) begin
      avg <= avg_next;
    end
    if (out_load) begin
      out_mean <= mean;
      out_avg  <= avg;
      out_cnt  <= count;
    end
  end

  assign sample.ready        = (state == ST_IDLE);
  assign result.valid        = out_valid;
  assign result.overall_bw   = out_mean;
  assign result.window_avg   = out_avg;
  assign result.sample_count = out_cnt;

endmodule

`default_nettype wire

// ----- hw/rtl/bwe_checker.sv -----
// ----------------------------------------------------------------------------
// Bandwidth estimator port checker
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bwe_checker import bwe_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_ready,
  input logic              result_valid,
  input logic              result_ready,
  input logic [MEAN_W-1:0] overall_bw,
  input logic [MEAN_W-1:0] window_avg,
  input logic [CNT_W-1:0]  sample_count
);

  `BWE_ASSERT(a_res_hold, clk, rst, result_valid && !result_ready |=> result_valid, "result dropped while stalled")
  `BWE_ASSERT(a_res_stable, clk, rst, result_valid && !result_ready |=> $stable(overall_bw) && $stable(window_avg), "result changed while stalled")
  `BWE_ASSERT(a_one_at_a_time, clk, rst, sample_valid && sample_ready |=> !sample_ready, "request taken while busy")
  `BWE_ASSERT(a_count_nonzero, clk, rst, result_valid |-> sample_count != '0, "zero sample count in result")
  `BWE_ASSERT_ALWAYS(a_reset_state, clk, rst |=> !result_valid && sample_ready, "not idle after reset")

endmodule

bind bandwidth_estimator_top bwe_checker u_bwe_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample.valid),
  .sample_ready (sample.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .overall_bw   (result.overall_bw),
  .window_avg   (result.window_avg),
  .sample_count (result.sample_count)
);

`default_nettype wire
